@@ rtl/core/rdpd_pkg.sv @@
// Shared types and constants for the remote debug packet deframer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rdpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int EV_W   = 3;
    localparam int DIG_W  = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Framing bytes
    localparam logic [BYTE_W-1:0] CH_START  = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_END    = 8'h23;  // '#'
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'h7d;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ACK    = 8'h2b;  // '+'
    localparam logic [BYTE_W-1:0] CH_NAK    = 8'h2d;  // '-'
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

    // Event codes on the result channel
    localparam logic [EV_W-1:0] EV_DATA     = 3'd0;
    localparam logic [EV_W-1:0] EV_RESTART  = 3'd1;
    localparam logic [EV_W-1:0] EV_ACCEPT   = 3'd2;
    localparam logic [EV_W-1:0] EV_BAD      = 3'd3;
    localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte; digit[4] set when the byte is not a hex digit
    typedef struct packed {
        logic [BYTE_W-1:0] raw;
        logic              is_start;
        logic              is_end;
        logic              is_esc;
        logic [DIG_W-1:0]  digit;
    } rdpd_item_t;

endpackage

@@ rtl/core/rdpd_rx_if.sv @@
// Receive byte channel: valid/ready handshake with one byte payload.
// Depends on rdpd_pkg.
`timescale 1ns / 1ps

interface rdpd_rx_if;
    import rdpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/rdpd_res_if.sv @@
// Result channel: valid/ready handshake carrying event, data byte and length.
// Depends on rdpd_pkg.
`timescale 1ns / 1ps

interface rdpd_res_if;
    import rdpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  payload_length;

    modport source (output valid, output event_res, output data, output payload_length,
                    input ready);
    modport sink   (input valid, input event_res, input data, input payload_length,
                    output ready);
endinterface

@@ rtl/core/rdpd_front.sv @@
// Front end: takes received bytes and classifies them for the back end.
// Depends on rdpd_pkg and rdpd_rx_if.
`timescale 1ns / 1ps

module rdpd_front (
    rdpd_rx_if.sink              rx,
    output logic                 push_valid,
    output rdpd_pkg::rdpd_item_t push_item,
    input  logic                 push_ready
);
    import rdpd_pkg::*;

    logic [BYTE_W-1:0] c;
    logic [DIG_W-1:0]  dig;

    assign c = rx.rx_byte;

    // Hex digit value, either case; 16 flags a non-hex byte
    always_comb
    begin
        if (c inside {[8'h61:8'h66]})
            dig = DIG_W'(c - 8'h61 + 8'd10);
        else if (c inside {[8'h30:8'h39]})
            dig = DIG_W'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            dig = DIG_W'(c - 8'h41 + 8'd10);
        else
            dig = DIG_W'(16);
    end

    always_comb
    begin
        push_item.raw      = c;
        push_item.is_start = (c == CH_START);
        push_item.is_end   = (c == CH_END);
        push_item.is_esc   = (c == CH_ESC);
        push_item.digit    = dig;
    end

    assign push_valid = rx.valid;
    assign rx.ready   = push_ready;

endmodule

@@ rtl/core/rdpd_queue.sv @@
// Short FIFO of classified bytes between front and back end.
// Depends on rdpd_pkg.
`timescale 1ns / 1ps

module rdpd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  rdpd_pkg::rdpd_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output rdpd_pkg::rdpd_item_t pop_item,
    input  logic                 pop
);
    import rdpd_pkg::*;

    rdpd_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/core/rdpd_back.sv @@
// Back end: packet state machine, checksum, length limit and result register.
// Depends on rdpd_pkg and rdpd_res_if.
`timescale 1ns / 1ps

module rdpd_back #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rdpd_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                        pop_valid,
    input  rdpd_pkg::rdpd_item_t        pop_item,
    output logic                        pop,
    rdpd_res_if.source                  res
);
    import rdpd_pkg::*;

    localparam int CAP_INT = (BUFFER_BYTES - 1 > int'(LEN_MAX)) ? int'(LEN_MAX)
                                                                : BUFFER_BYTES - 1;
    localparam logic [LEN_W-1:0] CAP = CAP_INT[LEN_W-1:0];

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_ESCAPED,
        PH_CK_HI,
        PH_CK_LO
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [DIG_W-1:0]  hi_reg, hi_next;
    logic [LEN_W-1:0]  max_payload_reg;
    logic [LEN_W-1:0]  limit;

    logic              out_valid_reg, out_valid_next;
    logic [EV_W-1:0]   out_ev_reg, out_ev_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              emit;
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] ev_data;
    logic [LEN_W-1:0]  ev_len;
    logic [LEN_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] data_val;
    logic              take;

    assign limit   = (max_payload_reg < CAP) ? max_payload_reg : CAP;
    assign pop     = pop_valid && (!out_valid_reg || res.ready);
    assign cnt_inc = count_reg + 1'b1;
    assign sum_add = sum_reg + pop_item.raw;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        hi_next    = hi_reg;
        emit       = 1'b0;
        ev         = EV_DATA;
        ev_data    = '0;
        ev_len     = '0;
        take       = 1'b0;
        data_val   = pop_item.raw;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                if (pop_item.is_start)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    emit       = 1'b1;
                    ev         = EV_RESTART;
                end
                else if (pop_item.is_end)
                    phase_next = PH_CK_HI;
                else
                begin
                    sum_next = sum_add;
                    if (pop_item.is_esc)
                        phase_next = PH_ESCAPED;
                    else
                        take = 1'b1;
                end
            end
            PH_ESCAPED:
            begin
                sum_next = sum_add;
                data_val = pop_item.raw ^ ESC_XOR;
                take     = 1'b1;
            end
            PH_CK_HI:
            begin
                hi_next    = pop_item.digit;
                phase_next = PH_CK_LO;
            end
            PH_CK_LO:
            begin
                phase_next = PH_HUNT;
                emit       = 1'b1;
                ev_len     = count_reg;
                if (!hi_reg[DIG_W-1] && !pop_item.digit[DIG_W-1]
                    && ({hi_reg[3:0], pop_item.digit[3:0]} == sum_reg))
                begin
                    ev      = EV_ACCEPT;
                    ev_data = CH_ACK;
                end
                else
                begin
                    ev      = EV_BAD;
                    ev_data = CH_NAK;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (pop_item.is_start)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    hi_next    = '0;
                    if (limit == '0)
                    begin
                        emit = 1'b1;
                        ev   = EV_OVERFLOW;
                    end
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
        endcase

        // Store one payload byte, or drop the packet once the limit is hit
        if (take)
        begin
            count_next = cnt_inc;
            emit       = 1'b1;
            ev_len     = cnt_inc;
            if (cnt_inc >= limit)
            begin
                phase_next = PH_HUNT;
                ev         = EV_OVERFLOW;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
                ev         = EV_DATA;
                ev_data    = data_val & BYTE_MASK;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = ev;
            out_data_next  = ev_data;
            out_len_next   = ev_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            sum_reg         <= '0;
            count_reg       <= '0;
            hi_reg          <= '0;
            max_payload_reg <= LEN_MAX;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_payload_reg <= cfg_wdata;
            if (pop)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
                hi_reg    <= hi_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ev_reg   <= out_ev_next;
        out_data_reg <= out_data_next;
        out_len_reg  <= out_len_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.event_res      = out_ev_reg;
    assign res.data           = out_data_reg;
    assign res.payload_length = out_len_reg;

    // A held result must never be overwritten by a new transaction
    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !pop)
        else $error("back end popped while result stalled");

    // Overflow reports exactly the limit in force
    a_overflow_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ev_reg == EV_OVERFLOW && !$rose(out_valid_reg)
         && $stable(max_payload_reg)) |-> (out_len_reg == limit)
        || $past(out_valid_reg && !res.ready))
        else $error("overflow length differs from limit");

    // Checksum verdicts carry the matching ack or nak byte
    a_verdict_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_ev_reg == EV_ACCEPT || out_ev_reg == EV_BAD))
        |-> (out_data_reg == ((out_ev_reg == EV_ACCEPT) ? CH_ACK : CH_NAK)))
        else $error("verdict byte mismatch");

    // A verdict always sends the state machine back to hunting
    a_verdict_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && phase_reg == PH_CK_LO) |=> (phase_reg == PH_HUNT))
        else $error("no return to hunting after checksum");

endmodule

@@ rtl/core/remote_debug_packet_deframer_unit.sv @@
// Top level of the remote debug packet deframer: front end, queue, back end.
// Depends on rdpd_pkg, rdpd_rx_if, rdpd_res_if, rdpd_front, rdpd_queue, rdpd_back.
`timescale 1ns / 1ps

// Receives the byte stream of a debug link, one byte per rx transaction, and
// reports payload bytes (unescaped), restarts, checksum verdicts ('+' / '-')
// and overflow drops on the res channel, at most one result per byte. Bytes
// are taken at one per cycle: the front end classifies each byte into a
// four-entry queue and the back end retires one queued byte per cycle into
// its result register, so the sustained rate is one byte per cycle as long
// as res is drained; a byte passes the queue and then the result register.
// max_payload (reset 1023) is written through cfg_we/cfg_wdata; the user must
// do so only while the block is idle, which the block does not enforce. The
// limit in force is the smaller of max_payload and BUFFER_BYTES - 1.
module remote_debug_packet_deframer_unit #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rdpd_rx_if.sink                    rx,
    rdpd_res_if.source                 res,
    input  logic                       cfg_we,
    input  logic [rdpd_pkg::LEN_W-1:0] cfg_wdata
);
    import rdpd_pkg::*;

    logic       push_valid;
    rdpd_item_t push_item;
    logic       push_ready;
    logic       pop_valid;
    rdpd_item_t pop_item;
    logic       pop;

    rdpd_front u_front (
        .rx         (rx),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    rdpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    rdpd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .res       (res)
    );

endmodule

@@ dv/rdpd_event_checker.sv @@
// Scoreboard for the packet deframer: watches the rx, res and config ports,
// predicts the result events and compares them. Depends on rdpd_pkg.
`timescale 1ns / 1ps

module rdpd_event_checker #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    input  logic                        rx_ready,
    input  logic [rdpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic [rdpd_pkg::EV_W-1:0]   event_res,
    input  logic [rdpd_pkg::BYTE_W-1:0] data,
    input  logic [rdpd_pkg::LEN_W-1:0]  payload_length,
    input  logic                        cfg_we,
    input  logic [rdpd_pkg::LEN_W-1:0]  cfg_wdata,
    output int                          error_count,
    output int                          pending_results
);
    import rdpd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_ESCAPED,
        PH_CK_HI,
        PH_CK_LO
    } frame_phase_t;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } deframe_event_t;

    frame_phase_t      phase;
    logic [BYTE_W-1:0] csum;
    logic [LEN_W-1:0]  count;
    logic [DIG_W-1:0]  hi_digit;
    logic [LEN_W-1:0]  max_len;
    deframe_event_t    expected_events[$];
    int                errs;

    // bit 4 set when the byte is not a hex digit
    function automatic logic [DIG_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
        if (c >= 8'h61 && c <= 8'h66) return DIG_W'(c - 8'h57);
        if (c >= 8'h30 && c <= 8'h39) return DIG_W'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return DIG_W'(c - 8'h37);
        return 5'h10;
    endfunction

    function automatic int active_limit();
        int cap = BUFFER_BYTES - 1;
        return (int'(max_len) < cap) ? int'(max_len) : cap;
    endfunction

    function automatic void note_event(input logic [EV_W-1:0] ev, input logic [BYTE_W-1:0] d,
                                       input logic [LEN_W-1:0] len);
        deframe_event_t e;
        e.ev   = ev;
        e.data = d;
        e.len  = len;
        expected_events.push_back(e);
    endfunction

    function automatic void take_payload(input logic [BYTE_W-1:0] value);
        count = count + 1'b1;
        if (int'(count) >= active_limit()) begin
            phase = PH_HUNT;
            note_event(EV_OVERFLOW, '0, count);
        end else begin
            phase = PH_PAYLOAD;
            note_event(EV_DATA, value, count);
        end
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] c);
        logic [DIG_W-1:0] lo_digit;
        case (phase)
            PH_PAYLOAD: begin
                if (c == CH_START) begin
                    csum  = '0;
                    count = '0;
                    note_event(EV_RESTART, '0, '0);
                end else if (c == CH_END) begin
                    phase = PH_CK_HI;
                end else begin
                    csum = csum + c;
                    if (c == CH_ESC)
                        phase = PH_ESCAPED;
                    else
                        take_payload(c);
                end
            end
            PH_ESCAPED: begin
                csum = csum + c;
                take_payload(c ^ ESC_XOR);
            end
            PH_CK_HI: begin
                hi_digit = hex_digit(c);
                phase    = PH_CK_LO;
            end
            PH_CK_LO: begin
                lo_digit = hex_digit(c);
                phase    = PH_HUNT;
                if (!hi_digit[4] && !lo_digit[4] && {hi_digit[3:0], lo_digit[3:0]} == csum)
                    note_event(EV_ACCEPT, CH_ACK, count);
                else
                    note_event(EV_BAD, CH_NAK, count);
            end
            default: begin
                phase = PH_HUNT;
                if (c == CH_START) begin
                    csum     = '0;
                    count    = '0;
                    hi_digit = '0;
                    if (active_limit() == 0)
                        note_event(EV_OVERFLOW, '0, '0);
                    else
                        phase = PH_PAYLOAD;
                end
            end
        endcase
    endfunction

    function automatic void check_result();
        deframe_event_t want;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected result: expected none, got event %0d data %02h len %0d",
                     $time, event_res, data, payload_length);
            errs++;
            return;
        end
        want = expected_events.pop_front();
        if (event_res !== want.ev) begin
            $display("%0t: event_res expected %0d, got %0d", $time, want.ev, event_res);
            errs++;
        end
        if (data !== want.data) begin
            $display("%0t: data expected %02h, got %02h", $time, want.data, data);
            errs++;
        end
        if (payload_length !== want.len) begin
            $display("%0t: payload_length expected %0d, got %0d", $time, want.len,
                     payload_length);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_HUNT;
            csum     = '0;
            count    = '0;
            hi_digit = '0;
            max_len  = LEN_MAX;
            errs     = 0;
            expected_events.delete();
            error_count     <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;
            // a byte accepted now cannot have its result on this same edge
            if (rx_valid && rx_ready)
                predict_byte(rx_byte);
            if (res_valid && res_ready)
                check_result();
            error_count     <= errs;
            pending_results <= expected_events.size();
        end
    end

endmodule

@@ dv/remote_debug_packet_deframer_unit_tb.sv @@
// Testbench top for the packet deframer: clock, reset, byte stimulus, result
// sink and verdict. Depends on rdpd_pkg, the rx/res interfaces and rdpd_event_checker.
`timescale 1ns / 1ps

module remote_debug_packet_deframer_unit_tb;
    import rdpd_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_PCT        = 13;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_ITEMS    = 1800;

    typedef enum int {CK_GOOD, CK_WRONG, CK_NOT_HEX} ck_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    int               mismatches;
    int               outstanding;
    int               items_sent;
    int               cur_limit;
    int               idle_cycles;
    int               random_end;
    bit               no_gaps;
    bit               hold_off_req;
    logic [BYTE_W-1:0] frame_body[$];

    rdpd_rx_if  rx_ch ();
    rdpd_res_if res_ch ();

    remote_debug_packet_deframer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rdpd_event_checker #(
        .BUFFER_BYTES (1024)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_ch.valid),
        .rx_ready        (rx_ch.ready),
        .rx_byte         (rx_ch.rx_byte),
        .res_valid       (res_ch.valid),
        .res_ready       (res_ch.ready),
        .event_res       (res_ch.event_res),
        .data            (res_ch.data),
        .payload_length  (res_ch.payload_length),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .error_count     (mismatches),
        .pending_results (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // result sink: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog: no transaction for %0d cycles", $time, idle_cycles);
                $display("remote_debug_packet_deframer_unit: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // lets everything in flight retire; the block may still hold a silent byte
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_limit(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = value;
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // raw payload bytes for len data bytes; specials only go out escaped
    function automatic void build_body(input int len);
        logic [BYTE_W-1:0] b;
        frame_body.delete();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                frame_body.push_back(CH_ESC);
                frame_body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                do b = BYTE_W'($urandom_range(0, 255));
                while (b == CH_START || b == CH_END || b == CH_ESC);
                frame_body.push_back(b);
            end
        end
    endfunction

    task automatic send_built_frame(input ck_mode_t mode);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] hi_ch;
        logic [BYTE_W-1:0] lo_ch;
        int                which;
        sum = '0;
        send_byte(CH_START);
        foreach (frame_body[i])
        begin
            sum = sum + frame_body[i];
            send_byte(frame_body[i]);
        end
        send_byte(CH_END);
        if (mode == CK_WRONG)
            sum = sum + BYTE_W'($urandom_range(1, 255));
        hi_ch = hex_char(sum[7:4]);
        lo_ch = hex_char(sum[3:0]);
        if (mode == CK_NOT_HEX)
        begin
            which = $urandom_range(0, 2);
            if (which != 1) hi_ch = BYTE_W'($urandom_range(8'h47, 8'h60));
            if (which != 0) lo_ch = BYTE_W'($urandom_range(8'h47, 8'h60));
        end
        send_byte(hi_ch);
        send_byte(lo_ch);
    endtask

    task automatic send_frame(input int len, input ck_mode_t mode);
        build_body(len);
        send_built_frame(mode);
    endtask

    function automatic int pick_len();
        int r;
        int lim;
        r   = $urandom_range(0, 99);
        lim = (cur_limit < 1023) ? cur_limit : 1023;
        if (r < 80) return $urandom_range(0, 12);
        if (r < 95) return $urandom_range(13, 60);
        if (lim <= 300) return $urandom_range((lim > 0) ? lim - 1 : 0, lim + 2);
        return $urandom_range(0, 12);
    endfunction

    task automatic send_random_unit();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_frame(pick_len(), CK_GOOD);
        else if (r < 78)
            send_frame(pick_len(), CK_WRONG);
        else if (r < 84)
            send_frame(pick_len(), CK_NOT_HEX);
        else if (r < 92)
        begin
            // partial packet, then a fresh '$' restarts it
            send_byte(CH_START);
            build_body($urandom_range(0, 6));
            foreach (frame_body[i]) send_byte(frame_body[i]);
            send_frame(pick_len(), CK_GOOD);
        end
        else
        begin
            k = $urandom_range(1, 4);
            repeat (k) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target && items_sent < random_end) send_random_unit();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        no_gaps       = 1'b0;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        cur_limit     = LEN_MAX;
        random_end    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise while hunting, empty packet, escaped specials,
        // restart with a bad checksum, '$' taken as a checksum digit
        send_byte(8'hff);
        frame_body.delete();
        send_built_frame(CK_GOOD);
        frame_body = '{CH_ESC, CH_START, CH_ESC, CH_END, CH_ESC, 8'h5d, 8'hff, 8'h00};
        send_built_frame(CK_GOOD);
        send_byte(CH_START);
        send_byte(8'h41);
        frame_body = '{8'h42};
        send_built_frame(CK_WRONG);
        send_byte(CH_START);
        send_byte(CH_END);
        send_byte(CH_START);
        send_byte(8'h30);

        random_end = items_sent + RANDOM_ITEMS;
        run_random(150);
        program_limit(1);
        run_random(100);
        program_limit(0);
        run_random(60);
        program_limit($urandom_range(2, 40));
        run_random(150);
        program_limit($urandom_range(41, 250));
        run_random(150);

        // full-size packet against a stalled sink, then overflow at the top count
        program_limit(LEN_MAX);
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        send_frame(LEN_MAX + 2, CK_GOOD);
        no_gaps = 1'b0;
        run_random(RANDOM_ITEMS);

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("remote_debug_packet_deframer_unit: match");
        else
            $display("remote_debug_packet_deframer_unit: mismatch");
        $finish;
    end

endmodule
